FILE: rtl/core/lz_byte_copy_decompressor_defines.svh
// assertion macros shared by the checker file
// no dependencies
`ifndef LZ_BYTE_COPY_DECOMPRESSOR_DEFINES_SVH
`define LZ_BYTE_COPY_DECOMPRESSOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define LZBC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lzbc check failed");
// next-cycle implication
`define LZBC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lzbc check failed");
`endif

FILE: rtl/core/lzbc_pkg.sv
// shared types and constants for the lz byte copy decompressor
// no dependencies
`default_nettype none
package lzbc_pkg;
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_BYTE  = 3'd1;
  localparam logic [2:0] ST_NEED  = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;
  localparam logic [2:0] ST_BUSY  = 3'd5;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_EMPTY = 3'd1;
  localparam logic [2:0] ERR_EARLY = 3'd2;
  localparam logic [2:0] ERR_OFS   = 3'd3;
  localparam logic [2:0] ERR_OVF   = 3'd4;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_REL   = 3'd0;
  localparam logic [2:0] ADDR_LIMIT = 3'd4;

  localparam logic [3:0] PH_FIRST = 4'd0;
  localparam logic [3:0] PH_CMD = 4'd1;
  localparam logic [3:0] PH_SHORT_OFF = 4'd2;
  localparam logic [3:0] PH_MED_LO = 4'd3;
  localparam logic [3:0] PH_MED_HI = 4'd4;
  localparam logic [3:0] PH_FILL_C0 = 4'd5;
  localparam logic [3:0] PH_FILL_C1 = 4'd6;
  localparam logic [3:0] PH_FILL_V = 4'd7;
  localparam logic [3:0] PH_LONG_C0 = 4'd8;
  localparam logic [3:0] PH_LONG_C1 = 4'd9;
  localparam logic [3:0] PH_LONG_P0 = 4'd10;
  localparam logic [3:0] PH_LONG_P1 = 4'd11;
  localparam logic [3:0] PH_LIT = 4'd12;
  localparam logic [3:0] PH_DONE = 4'd13;
  localparam logic [3:0] PH_ERR = 4'd14;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;
  localparam logic [1:0] KIND_LIT  = 2'd3;

  localparam logic [6:0] LIT_MASK = 7'h3F;
  localparam logic [16:0] SHORT_BIAS = 17'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [2:0]  error_code;
    logic [16:0] out_length;
  } result_t;

  // one history access request from the parser
  typedef struct packed {
    logic        we;
    logic        rd;
    logic        use_fill;
    logic        src_ok;
  } hist_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/core/lz_byte_copy_decompressor.sv
// Decompressor for LCW byte-copy streams. One word in, one word out, one word per
// cycle sustained: each push or pull does one history read-modify-write and the
// copy byte returns from the synchronous history memory in the next cycle into the
// output stage, where it is also written back, with forwarding for a read of the
// same entry. Input is stalled only while the output stage is full and not taken.
`default_nettype none
module lz_byte_copy_decompressor #(
  parameter int OUT_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // command[1:0], in_byte[9:2], zero fill
  input  wire logic        in_tlast,   // in_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // status, out_byte, error_code, out_length, zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import lzbc_pkg::*;
  localparam int AW = $clog2(OUT_BYTES);

  logic        relm_r;
  logic [16:0] lim_r;
  logic        go, adv, rv;
  result_t     res;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relm_r <= 1'b0; lim_r <= 17'h10000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_REL) relm_r <= cfg_pwdata[0];
      else if (cfg_paddr == ADDR_LIMIT) lim_r <= cfg_pwdata[16:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == ADDR_REL) ? {31'd0, relm_r} :
                      ((cfg_paddr == ADDR_LIMIT) ? {15'd0, lim_r} : 32'd0);

  assign adv       = !rv || out_tready;
  assign in_tready = adv;
  assign go        = in_tvalid && adv;

  lzbc_parser #(.AW(AW), .OUT_BYTES(OUT_BYTES)) u_parser (
    .clk (clk), .rst_n (rst_n), .go (go),
    .command (in_tdata[1:0]), .in_byte (in_tdata[9:2]), .in_last (in_tlast),
    .relative_mode (relm_r), .output_limit (lim_r), .adv (adv),
    .res_valid (rv), .res (res)
  );

  assign out_tvalid = rv;
  assign out_tdata  = {1'b0, res.out_length, res.error_code, res.out_byte, res.status};
endmodule
`default_nettype wire

FILE: rtl/core/lzbc_history.sv
// history memory with one write and one registered read port, write forwarding
// no dependencies
`default_nettype none
module lzbc_history #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [2**AW];
  logic [7:0] q_r;
  logic [7:0] fwd_r;
  logic       hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r   <= mem[raddr];
      hit_r <= we && (waddr == raddr);
      fwd_r <= wdata;
    end
  end

  assign rdata = hit_r ? fwd_r : q_r;
endmodule
`default_nettype wire

FILE: rtl/core/lzbc_parser.sv
// command parser and copy engine; drives the history memory, forms one result
// depends on lzbc_pkg and lzbc_history
`default_nettype none
module lzbc_parser #(
  parameter int AW = 16,
  parameter int OUT_BYTES = 65536
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic [1:0]      command,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic            relative_mode,
  input  wire logic [16:0]     output_limit,
  input  wire logic            adv,
  output logic                 res_valid,
  output lzbc_pkg::result_t    res
);
  import lzbc_pkg::*;

  localparam logic [16:0] OutBytes = 17'(OUT_BYTES);

  logic [16:0] wpos_r, wpos_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [23:0] opnd_r, opnd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] src_r, src_nxt;
  logic [7:0]  fillv_r, fillv_nxt;
  logic        srel_r, srel_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        ended_r, ended_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        litovf_r, litovf_nxt;

  logic [2:0]  st;
  logic [7:0]  ob;
  logic        do_copy, hist_we;
  logic [7:0]  hist_wd;
  logic [7:0]  rdata;
  logic [16:0] lim;
  logic        pend;

  // delayed output stage: copy byte arrives from memory in the next cycle
  logic        v_r, cp_r, zero_r;
  result_t     res_r;

  // history write lands the cycle after the word, once a copy byte is known
  logic          wr_r;
  logic [AW-1:0] waddr_r;
  logic [7:0]    wdat_r;
  logic [7:0]    cur_copy;

  logic [16:0] cnt, pos, csrc;
  logic        crel;
  logic        fin;

  assign lim  = (output_limit > OutBytes) ? OutBytes : output_limit;
  assign pend = (kind_r == KIND_COPY || kind_r == KIND_FILL) && rem_r != 16'd0;

  always_comb begin
    wpos_nxt = wpos_r; phase_nxt = phase_r; opnd_nxt = opnd_r; rem_nxt = rem_r;
    src_nxt = src_r; fillv_nxt = fillv_r; srel_nxt = srel_r; kind_nxt = kind_r;
    ended_nxt = ended_r; err_nxt = err_r; litovf_nxt = litovf_r;
    st = ST_NONE; ob = 8'd0; do_copy = 1'b0; hist_we = 1'b0; hist_wd = in_byte;
    cnt = 17'd0; pos = 17'd0; crel = 1'b0; fin = 1'b0; csrc = 17'd0;
    if (go) begin
      if (command == CMD_START) begin
        wpos_nxt = '0; phase_nxt = PH_FIRST; opnd_nxt = '0; rem_nxt = '0;
        src_nxt = '0; fillv_nxt = '0; srel_nxt = relative_mode; kind_nxt = KIND_NONE;
        ended_nxt = 1'b0; err_nxt = ERR_NONE; litovf_nxt = 1'b0; st = ST_NEED;
        if (in_last) begin
          err_nxt = ERR_EMPTY; phase_nxt = PH_ERR; st = ST_ERR;
        end
      end else if (command == CMD_PULL) begin
        if (pend) begin
          st = ST_BYTE;
          hist_we = 1'b1;
          if (kind_r == KIND_FILL) begin
            ob = fillv_r; hist_wd = fillv_r;
          end else begin
            do_copy = 1'b1;
          end
          src_nxt = src_r + 17'd1;
          wpos_nxt = wpos_r + 17'd1;
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            kind_nxt = KIND_NONE;
            if (ended_r) phase_nxt = PH_DONE;
          end
        end else if (phase_r == PH_ERR) begin
          st = ST_ERR;
        end else if (phase_r == PH_DONE) begin
          st = ST_DONE;
        end else begin
          st = ST_NEED;
        end
      end else if (command == CMD_PUSH) begin
        if (phase_r == PH_ERR) begin
          st = ST_ERR;
        end else if (phase_r == PH_DONE) begin
          st = ST_DONE;
        end else if (pend) begin
          st = ST_BUSY;
        end else begin
          unique case (phase_r)
            PH_FIRST, PH_CMD: begin
              phase_nxt = PH_CMD;
              if (phase_r == PH_FIRST && in_byte == 8'd0) begin
                srel_nxt = 1'b1;
                if (in_last) begin
                  phase_nxt = PH_DONE; st = ST_DONE;
                end
              end else if (in_byte < 8'h80) begin
                if (in_last) begin
                  err_nxt = ERR_EARLY; st = ST_ERR;
                end else begin
                  opnd_nxt = {16'd0, in_byte}; phase_nxt = PH_SHORT_OFF;
                end
              end else if (in_byte < 8'hC0) begin
                if (in_byte[5:0] == 6'd0) begin
                  phase_nxt = PH_DONE; st = ST_DONE;
                end else if (in_last) begin
                  err_nxt = ERR_EARLY; st = ST_ERR;
                end else begin
                  rem_nxt = {10'd0, in_byte[5:0]}; kind_nxt = KIND_LIT;
                  litovf_nxt = (wpos_r + {11'd0, in_byte[5:0]}) > lim;
                  phase_nxt = PH_LIT;
                end
              end else if (in_last) begin
                err_nxt = ERR_EARLY; st = ST_ERR;
              end else begin
                opnd_nxt = {16'd0, in_byte};
                phase_nxt = (in_byte < 8'hFE) ? PH_MED_LO :
                            ((in_byte == 8'hFE) ? PH_FILL_C0 : PH_LONG_C0);
              end
            end
            PH_SHORT_OFF: begin
              fin = 1'b1; crel = 1'b1;
              cnt = {14'd0, opnd_r[6:4]} + SHORT_BIAS;
              pos = {5'd0, opnd_r[3:0], in_byte};
            end
            PH_MED_LO, PH_FILL_C1, PH_LONG_C1: begin
              if (in_last) begin
                err_nxt = ERR_EARLY; st = ST_ERR;
              end else begin
                opnd_nxt = {opnd_r[23:16], in_byte, opnd_r[7:0]};
                phase_nxt = (phase_r == PH_MED_LO) ? PH_MED_HI :
                            ((phase_r == PH_FILL_C1) ? PH_FILL_V : PH_LONG_P0);
              end
            end
            PH_MED_HI: begin
              fin = 1'b1; crel = srel_r;
              cnt = {11'd0, opnd_r[5:0]} + SHORT_BIAS;
              pos = {1'b0, in_byte, opnd_r[15:8]};
            end
            PH_FILL_C0, PH_LONG_C0: begin
              if (in_last) begin
                err_nxt = ERR_EARLY; st = ST_ERR;
              end else begin
                opnd_nxt = {16'd0, in_byte};
                phase_nxt = (phase_r == PH_FILL_C0) ? PH_FILL_C1 : PH_LONG_C1;
              end
            end
            PH_FILL_V: begin
              if ((wpos_r + {1'b0, opnd_r[15:0]}) > lim) begin
                err_nxt = ERR_OVF; st = ST_ERR;
              end else begin
                fillv_nxt = in_byte; rem_nxt = opnd_r[15:0]; kind_nxt = KIND_FILL;
                phase_nxt = PH_CMD;
                if (opnd_r[15:0] == 16'd0) kind_nxt = KIND_NONE;
                if (in_last) begin
                  ended_nxt = 1'b1;
                  if (opnd_r[15:0] == 16'd0) begin
                    phase_nxt = PH_DONE; st = ST_DONE;
                  end
                end
              end
            end
            PH_LONG_P0: begin
              if (in_last) begin
                err_nxt = ERR_EARLY; st = ST_ERR;
              end else begin
                opnd_nxt = {in_byte, opnd_r[15:0]}; phase_nxt = PH_LONG_P1;
              end
            end
            PH_LONG_P1: begin
              fin = 1'b1; crel = srel_r;
              cnt = {1'b0, opnd_r[15:0]};
              pos = {1'b0, in_byte, opnd_r[23:16]};
            end
            PH_LIT: begin
              rem_nxt = rem_r - 16'd1;
              if (litovf_r) begin
                if (rem_r == 16'd1) begin
                  err_nxt = ERR_OVF; st = ST_ERR;
                end else if (in_last) begin
                  err_nxt = ERR_EARLY; st = ST_ERR;
                end
              end else if (rem_r != 16'd1 && in_last) begin
                err_nxt = ERR_EARLY; st = ST_ERR;
              end else begin
                hist_we = 1'b1; wpos_nxt = wpos_r + 17'd1; st = ST_BYTE; ob = in_byte;
                if (rem_r == 16'd1) begin
                  kind_nxt = KIND_NONE;
                  phase_nxt = in_last ? PH_DONE : PH_CMD;
                end
              end
            end
            default: st = ST_NONE;
          endcase
          if (fin) begin
            csrc = wpos_r - pos;
            if (crel ? (pos == 17'd0 || pos > wpos_r) : (pos > wpos_r)) begin
              err_nxt = ERR_OFS; st = ST_ERR;
            end else if ((wpos_r + cnt) > lim) begin
              err_nxt = ERR_OVF; st = ST_ERR;
            end else begin
              src_nxt = crel ? csrc : pos;
              rem_nxt = cnt[15:0]; kind_nxt = KIND_COPY; phase_nxt = PH_CMD;
              if (cnt == 17'd0) kind_nxt = KIND_NONE;
              if (in_last) begin
                ended_nxt = 1'b1;
                if (cnt == 17'd0) begin
                  phase_nxt = PH_DONE; st = ST_DONE;
                end
              end
            end
          end
          if (st == ST_ERR) begin
            phase_nxt = PH_ERR; kind_nxt = KIND_NONE; rem_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0; phase_r <= PH_FIRST; opnd_r <= '0; rem_r <= '0; src_r <= '0;
      fillv_r <= '0; srel_r <= 1'b0; kind_r <= KIND_NONE; ended_r <= 1'b0;
      err_r <= ERR_NONE; litovf_r <= 1'b0; v_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      wpos_r <= wpos_nxt; phase_r <= phase_nxt; opnd_r <= opnd_nxt; rem_r <= rem_nxt;
      src_r <= src_nxt; fillv_r <= fillv_nxt; srel_r <= srel_nxt; kind_r <= kind_nxt;
      ended_r <= ended_nxt; err_r <= err_nxt; litovf_r <= litovf_nxt;
      wr_r <= hist_we && wpos_r < OutBytes;
      if (adv) v_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    waddr_r <= wpos_r[AW-1:0];
    wdat_r  <= hist_wd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp_r   <= do_copy;
      zero_r <= !(src_r < wpos_r && src_r < OutBytes);
      res_r  <= '{status: st, out_byte: ob, error_code: err_nxt, out_length: wpos_nxt};
    end
  end

  // copy byte of the previous word, written back while the next word reads
  assign cur_copy = zero_r ? 8'd0 : rdata;

  lzbc_history #(.AW(AW)) u_hist (
    .clk   (clk),
    .we    (wr_r),
    .waddr (waddr_r),
    .wdata (cp_r ? cur_copy : wdat_r),
    .re    (adv),
    .raddr (src_r[AW-1:0]),
    .rdata (rdata)
  );

  assign res_valid = v_r;
  always_comb begin
    res = res_r;
    if (cp_r) res.out_byte = cur_copy;
  end
endmodule
`default_nettype wire

FILE: rtl/core/lzbc_checker.sv
// port-level checker for the decompressor, bound to the top level
// depends on lz_byte_copy_decompressor_defines.svh and lzbc_pkg
`default_nettype none
`include "lz_byte_copy_decompressor_defines.svh"
module lzbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  import lzbc_pkg::*;
  `LZBC_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready)
  `LZBC_ASSERT_IMP(a_byte0, clk, rst_n, out_tvalid && out_tdata[2:0] != ST_BYTE,
                   out_tdata[10:3] == 8'd0)
  `LZBC_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
bind lz_byte_copy_decompressor lzbc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

FILE: tb/tb_lz_byte_copy_decompressor.sv
// self-checking testbench for lz_byte_copy_decompressor: directed rows, then random
// lcw command streams, checked against a behavioral decoder; depends on lzbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tb_lz_byte_copy_decompressor;
  import lzbc_pkg::*;

  localparam int HIST_BYTES = 65536;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #1 clk = ~clk;

  lz_byte_copy_decompressor dut (.*);

  // decoder model state
  logic [7:0] hist [HIST_BYTES];
  int unsigned wr_pos, opnd, remain, src, cfg_lim;
  logic [3:0] phase;
  logic [1:0] kind;
  logic [7:0] fill_val;
  logic [2:0] err_st;
  bit srel, ended, cfg_rel;

  result_t expected_words[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int quiet_cycles = 0;
  logic [7:0] seq_bytes[$];

  function automatic int unsigned eff_limit();
    return (cfg_lim > HIST_BYTES) ? HIST_BYTES : cfg_lim;
  endfunction

  function automatic void open_stream();
    wr_pos = 0; phase = PH_FIRST; opnd = 0; remain = 0; src = 0; fill_val = 0;
    srel = cfg_rel; kind = KIND_NONE; ended = 0; err_st = ERR_NONE;
  endfunction

  function automatic logic [2:0] fail(logic [2:0] code);
    err_st = code; phase = PH_ERR; kind = KIND_NONE; remain = 0;
    return ST_ERR;
  endfunction

  function automatic logic [2:0] end_cmd(bit last);
    phase = PH_CMD;
    if (remain == 0) kind = KIND_NONE;
    if (last) begin
      ended = 1;
      if (remain == 0) begin
        phase = PH_DONE;
        return ST_DONE;
      end
    end
    return ST_NONE;
  endfunction

  function automatic logic [2:0] start_copy(int unsigned cnt, int unsigned pos, bit rel,
                                            bit last);
    if (rel) begin
      if (pos == 0 || pos > wr_pos) return fail(ERR_OFS);
      src = wr_pos - pos;
    end else begin
      if (pos > wr_pos) return fail(ERR_OFS);
      src = pos;
    end
    if (wr_pos + cnt > eff_limit()) return fail(ERR_OVF);
    remain = cnt;
    kind = KIND_COPY;
    return end_cmd(last);
  endfunction

  function automatic logic [2:0] take_cmd(int unsigned b, bit last);
    int unsigned n;
    if (b < 'h80) begin
      if (last) return fail(ERR_EARLY);
      opnd = b; phase = PH_SHORT_OFF;
      return ST_NONE;
    end
    if (b < 'hC0) begin
      n = b & 'h3F;
      if (n == 0) begin
        phase = PH_DONE;
        return ST_DONE;
      end
      if (last) return fail(ERR_EARLY);
      remain = n; kind = KIND_LIT;
      opnd = (wr_pos + n > eff_limit()) ? 1 : 0;
      phase = PH_LIT;
      return ST_NONE;
    end
    if (last) return fail(ERR_EARLY);
    opnd = b;
    phase = (b < 'hFE) ? PH_MED_LO : ((b == 'hFE) ? PH_FILL_C0 : PH_LONG_C0);
    return ST_NONE;
  endfunction

  function automatic logic [2:0] push_byte(int unsigned b, bit last, ref logic [7:0] ob);
    if (phase == PH_ERR) return ST_ERR;
    if (phase == PH_DONE) return ST_DONE;
    if ((kind == KIND_COPY || kind == KIND_FILL) && remain > 0) return ST_BUSY;
    case (phase)
      PH_FIRST: begin
        phase = PH_CMD;
        if (b == 0) begin
          srel = 1;
          if (last) begin
            phase = PH_DONE;
            return ST_DONE;
          end
          return ST_NONE;
        end
        return take_cmd(b, last);
      end
      PH_CMD: return take_cmd(b, last);
      PH_SHORT_OFF:
        return start_copy(((opnd & 'h70) >> 4) + 3, ((opnd & 'h0F) << 8) | b, 1, last);
      PH_MED_LO, PH_FILL_C1, PH_LONG_C1: begin
        if (last) return fail(ERR_EARLY);
        opnd |= b << 8;
        phase = (phase == PH_MED_LO) ? PH_MED_HI :
                (phase == PH_FILL_C1) ? PH_FILL_V : PH_LONG_P0;
        return ST_NONE;
      end
      PH_MED_HI:
        return start_copy((opnd & 'h3F) + 3, ((opnd >> 8) & 'hFF) | (b << 8), srel, last);
      PH_FILL_C0, PH_LONG_C0: begin
        if (last) return fail(ERR_EARLY);
        opnd = b;
        phase = (phase == PH_FILL_C0) ? PH_FILL_C1 : PH_LONG_C1;
        return ST_NONE;
      end
      PH_FILL_V: begin
        if (wr_pos + (opnd & 'hFFFF) > eff_limit()) return fail(ERR_OVF);
        fill_val = b[7:0]; remain = opnd & 'hFFFF; kind = KIND_FILL;
        return end_cmd(last);
      end
      PH_LONG_P0: begin
        if (last) return fail(ERR_EARLY);
        opnd |= b << 16; phase = PH_LONG_P1;
        return ST_NONE;
      end
      PH_LONG_P1:
        return start_copy(opnd & 'hFFFF, ((opnd >> 16) & 'hFF) | (b << 8), srel, last);
      default: begin
        remain--;
        if (opnd & 1) begin
          if (remain == 0) return fail(ERR_OVF);
          if (last) return fail(ERR_EARLY);
          return ST_NONE;
        end
        if (remain != 0 && last) return fail(ERR_EARLY);
        if (wr_pos < HIST_BYTES) hist[wr_pos] = b[7:0];
        wr_pos++;
        ob = b[7:0];
        if (remain == 0) begin
          kind = KIND_NONE;
          phase = last ? PH_DONE : PH_CMD;
        end
        return ST_BYTE;
      end
    endcase
  endfunction

  function automatic logic [2:0] pull_byte(ref logic [7:0] ob);
    logic [7:0] v;
    if ((kind == KIND_COPY || kind == KIND_FILL) && remain > 0) begin
      if (kind == KIND_FILL) v = fill_val;
      else v = (src < wr_pos && src < HIST_BYTES) ? hist[src] : 8'd0;
      src = (src + 1) & 'h1FFFF;
      if (wr_pos < HIST_BYTES) hist[wr_pos] = v;
      wr_pos++;
      remain--;
      if (remain == 0) begin
        kind = KIND_NONE;
        if (ended) phase = PH_DONE;
      end
      ob = v;
      return ST_BYTE;
    end
    if (phase == PH_ERR) return ST_ERR;
    if (phase == PH_DONE) return ST_DONE;
    return ST_NEED;
  endfunction

  function automatic result_t lcw_step(logic [1:0] cmd, logic [7:0] b, bit last);
    logic [2:0] st;
    logic [7:0] ob;
    result_t r;
    ob = 8'd0;
    case (cmd)
      CMD_START: begin
        open_stream();
        st = last ? fail(ERR_EMPTY) : ST_NEED;
      end
      CMD_PUSH: st = push_byte(b, last, ob);
      CMD_PULL: st = pull_byte(ob);
      default: st = ST_NONE;
    endcase
    if (st != ST_BYTE) ob = 8'd0;
    r.status = st; r.out_byte = ob; r.error_code = err_st; r.out_length = wr_pos[16:0];
    return r;
  endfunction

  // result side: random stall, check, watchdog
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.out_byte = out_tdata[10:3];
        got.error_code = out_tdata[13:11];
        got.out_length = out_tdata[30:14];
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t unexpected word: actual %h", $realtime, got);
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.out_byte !== want.out_byte ||
              got.error_code !== want.error_code || got.out_length !== want.out_length) begin
            errors++;
            $display("%0t mismatch: expected st/byte/err/len %0d/%h/%0d/%0d, actual %0d/%h/%0d/%0d",
                     $realtime, want.status, want.out_byte, want.error_code, want.out_length,
                     got.status, got.out_byte, got.error_code, got.out_length);
          end
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_stall);
  end

  task automatic send(logic [1:0] c, logic [7:0] b, bit l, bit has, result_t r);
    result_t pr;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, b, c};
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    pr = lcw_step(c, b, l);
    expected_words.push_back(has ? r : pr);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_REL) cfg_rel = data[0];
    else cfg_lim = data[16:0];
  endtask

  function automatic int unsigned pick_pos(bit rel, int unsigned cap);
    int unsigned top;
    if ($urandom_range(99) < 8) return $urandom_range(cap);
    top = (wr_pos > cap) ? cap : wr_pos;
    if (rel) return (top == 0) ? 0 : $urandom_range(top, 1);
    return $urandom_range(top);
  endfunction

  // queue one well-formed command with random content
  function automatic void build_command();
    int unsigned n, p;
    if (phase == PH_FIRST && $urandom_range(3) == 0) seq_bytes.push_back(8'h00);
    case ($urandom_range(5))
      0: begin
        n = $urandom_range(6, 1);
        seq_bytes.push_back(8'h80 | n[7:0]);
        repeat (n) seq_bytes.push_back(8'($urandom_range(255)));
      end
      1: begin
        p = pick_pos(1, 4095);
        seq_bytes.push_back({1'b0, 3'($urandom_range(7)), p[11:8]});
        seq_bytes.push_back(p[7:0]);
      end
      2: begin
        p = pick_pos(srel, 65535);
        seq_bytes.push_back(8'hC0 | 8'($urandom_range(61)));
        seq_bytes.push_back(p[7:0]); seq_bytes.push_back(p[15:8]);
      end
      3: begin
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        seq_bytes.push_back(8'hFE);
        seq_bytes.push_back(n[7:0]); seq_bytes.push_back(n[15:8]);
        seq_bytes.push_back(8'($urandom_range(255)));
      end
      4: begin
        n = $urandom_range(10);
        p = pick_pos(srel, 65535);
        seq_bytes.push_back(8'hFF);
        seq_bytes.push_back(n[7:0]); seq_bytes.push_back(n[15:8]);
        seq_bytes.push_back(p[7:0]); seq_bytes.push_back(p[15:8]);
      end
      default: seq_bytes.push_back(8'h80);
    endcase
  endfunction

  task automatic random_item(bit force_start);
    logic [1:0] c;
    logic [7:0] b;
    bit l;
    int r;
    r = $urandom_range(99);
    b = 8'($urandom_range(255));
    l = 0;
    if (force_start || ((phase == PH_DONE || phase == PH_ERR) && r < 80)) begin
      c = CMD_START; l = ($urandom_range(24) == 0); seq_bytes.delete();
    end else if ((kind == KIND_COPY || kind == KIND_FILL) && remain > 0) begin
      c = (r < 90) ? CMD_PULL : ((r < 96) ? CMD_PUSH : 2'($urandom_range(3)));
    end else if (r < 6 || phase == PH_DONE || phase == PH_ERR) begin
      c = 2'($urandom_range(3)); l = ($urandom_range(7) == 0);
      if (c == CMD_START || c == CMD_PUSH) seq_bytes.delete();
    end else begin
      c = CMD_PUSH;
      if (seq_bytes.size() == 0 && (phase == PH_CMD || phase == PH_FIRST)) build_command();
      if (seq_bytes.size() != 0) b = seq_bytes.pop_front();
      l = (seq_bytes.size() == 0 && $urandom_range(9) == 0) || $urandom_range(49) == 0;
    end
    send(c, b, l, 0, '0);
  endtask

  typedef struct {
    logic [1:0] c;
    logic [7:0] b;
    bit l;
    bit has;
    result_t r;
  } dir_row_t;

  function automatic dir_row_t row(logic [1:0] c, logic [7:0] b, bit l);
    dir_row_t d;
    d.c = c; d.b = b; d.l = l; d.has = 0; d.r = '0;
    return d;
  endfunction

  function automatic dir_row_t row_x(logic [1:0] c, logic [7:0] b, bit l,
                                     logic [2:0] st, logic [2:0] e, logic [16:0] len);
    dir_row_t d;
    d = row(c, b, l);
    d.has = 1; d.r = '{st, 8'd0, e, len};
    return d;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    int unsigned phase_cfg[7][2];
    int count;
    phase_cfg = '{'{1, 65536}, '{0, 0}, '{1, 131071}, '{0, 37},
                  '{1, 300}, '{0, 1}, '{0, 65536}};
    cfg_rel = 0; cfg_lim = 65536;
    open_stream();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      row_x(CMD_PULL, 8'h00, 0, ST_NEED, ERR_NONE, 0),
      row_x(2'd3, 8'hFF, 1, ST_NONE, ERR_NONE, 0),
      row_x(CMD_START, 8'h00, 1, ST_ERR, ERR_EMPTY, 0),
      row_x(CMD_PUSH, 8'h12, 0, ST_ERR, ERR_EMPTY, 0),
      row_x(CMD_START, 8'h00, 0, ST_NEED, ERR_NONE, 0),
      row(CMD_PUSH, 8'h00, 0), row(CMD_PUSH, 8'h83, 0), row(CMD_PUSH, 8'hFF, 0),
      row(CMD_PUSH, 8'h00, 0), row(CMD_PUSH, 8'h5A, 0), row(CMD_PUSH, 8'h10, 0),
      row(CMD_PUSH, 8'h02, 0), row(CMD_PUSH, 8'h55, 0), row(CMD_PULL, 8'h00, 0),
      row(CMD_PULL, 8'h00, 0), row(CMD_PULL, 8'h00, 0), row(CMD_PULL, 8'h00, 0),
      row(CMD_PUSH, 8'hFE, 0), row(CMD_PUSH, 8'h01, 0), row(CMD_PUSH, 8'h00, 0),
      row(CMD_PUSH, 8'hAB, 0), row(CMD_PULL, 8'h00, 0),
      row(CMD_PUSH, 8'hC0, 0), row(CMD_PUSH, 8'h00, 0),
      row_x(CMD_PUSH, 8'h00, 0, ST_ERR, ERR_OFS, 8),
      row_x(CMD_START, 8'h00, 0, ST_NEED, ERR_NONE, 0),
      row_x(CMD_PUSH, 8'h80, 0, ST_DONE, ERR_NONE, 0),
      row_x(CMD_PUSH, 8'h81, 1, ST_DONE, ERR_NONE, 0)
    };
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].b, dir_rows[i].l,
                               dir_rows[i].has, dir_rows[i].r);

    count = 0;
    for (int p = 0; p < 7; p++) begin
      drain();
      cfg_write(ADDR_REL, phase_cfg[p][0]);
      cfg_write(ADDR_LIMIT, phase_cfg[p][1]);
      for (int k = 0; k < 120; k++) begin
        if (count < 280) begin
          snd_idle = 27; rcv_stall = 56;
        end else if (count < 560) begin
          snd_idle = 56; rcv_stall = 27;
        end else begin
          snd_idle = 0; rcv_stall = 0;
        end
        if (p == 2 && k == 60) drain();
        random_item(k == 0);
        count++;
      end
    end
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
